// ----- sv/flc_pkg.sv -----
// Shared types and constants for the full linear convolution block.
// Used by the tap cell, the controller and the top level; depends on nothing.
package flc_pkg;

    // Widths of the sample, coefficient, product and output words.
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 37;
    localparam int IDX_W   = 5;
    localparam int TAPS_W  = 6;

    // Upper bound on the taps in use, set by the number of results one item may give.
    localparam int RESULT_LIMIT = 32;

    // Reset value of the taps-in-use register.
    localparam logic [TAPS_W-1:0] TAPS_RESET = 6'd32;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Control word broadcast from the controller to every tap cell.
    typedef struct packed {
        logic                     shift;
        logic                     clear;
        logic                     coef_we;
        logic signed [DATA_W-1:0] shift_data;
    } cell_ctrl_t;

endpackage

// ----- sv/flc_cell.sv -----
// One tap cell of the convolution chain: delay-line tap, coefficient, product
// and partial-sum registers. Depends on flc_pkg.
module flc_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flc_pkg::cell_ctrl_t             ctrl,
    input  logic                            coef_sel,
    input  logic                            tap_en,
    input  logic signed [flc_pkg::DATA_W-1:0] sample_in,
    input  logic signed [flc_pkg::DATA_W-1:0] coef_in,
    output logic signed [flc_pkg::DATA_W-1:0] sample_out,
    input  logic signed [flc_pkg::ACC_W-1:0]  acc_in,
    output logic signed [flc_pkg::ACC_W-1:0]  acc_out
);
    import flc_pkg::*;

    logic signed [DATA_W-1:0] d_reg;
    logic signed [DATA_W-1:0] c_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Delay-line tap and coefficient, both cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                d_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                d_reg <= sample_in;
            end
            if (ctrl.coef_we && coef_sel)
            begin
                c_reg <= coef_in;
            end
        end
    end

    // The product is registered from the delay-line tap and coefficient; the partial sum picks it up
    // as the wave passes this cell. Cells beyond the taps in use add nothing.
    always_comb
    begin
        prod_next = d_reg * c_reg;
        acc_next  = acc_in + (tap_en ? ACC_W'(prod_reg) : '0);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign sample_out = d_reg;
    assign acc_out    = acc_reg;

endmodule

// ----- sv/flc_ctrl.sv -----
// Sequencer of the convolution block: input and configuration handshakes,
// tail flush, wave timing and the output register. Depends on flc_pkg.
module flc_ctrl #(
    parameter int TAPS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              req_type,
    input  logic                              sample_last,
    input  logic signed [flc_pkg::DATA_W-1:0] data_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flc_pkg::TAPS_W-1:0]        cfg_data,
    input  logic signed [flc_pkg::ACC_W-1:0]  acc_sel,
    output flc_pkg::cell_ctrl_t               ctrl,
    output logic [flc_pkg::TAPS_W-1:0]        act_taps,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [flc_pkg::ACC_W-1:0]  m_value,
    output logic                              m_last
);
    import flc_pkg::*;

    localparam int TAP_LIMIT = (TAPS < RESULT_LIMIT) ? TAPS : RESULT_LIMIT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [TAPS_W-1:0]        taps_reg;
    logic [TAPS_W-1:0]        cnt_reg;
    logic [TAPS_W-1:0]        cnt_next;
    logic [TAPS_W-1:0]        rem_reg;
    logic [TAPS_W-1:0]        rem_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [ACC_W-1:0]  m_value_reg;
    logic                     m_last_reg;
    logic [TAPS_W-1:0]        act;
    logic                     accept;
    logic                     done_calc;
    logic                     capture;

    // Clamp the configured tap count to the range the chain supports.
    always_comb
    begin
        act = taps_reg;
        if (taps_reg == '0)
        begin
            act = TAPS_W'(1);
        end
        else if (taps_reg > TAPS_W'(TAP_LIMIT))
        begin
            act = TAPS_W'(TAP_LIMIT);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Done once the sum wave has reached the last active cell; the counter restarts at each shift.
    assign done_calc = (state_reg == ST_CALC) && (cnt_reg == act + TAPS_W'(1));
    assign capture   = done_calc && (!m_valid_reg || m_ready);

    // Cell controls: shift a sample in, shift a zero in during the tail, write a
    // coefficient, or clear the delay line after the final output.
    always_comb
    begin
        ctrl.shift      = (accept && (req_type == REQ_SAMPLE)) || (capture && (rem_reg != '0));
        ctrl.clear      = capture && (rem_reg == '0) && last_reg;
        ctrl.coef_we    = accept && (req_type == REQ_COEF);
        ctrl.shift_data = capture ? '0 : data_value;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_SAMPLE))
                begin
                    state_next = ST_CALC;
                    cnt_next   = '0;
                    last_next  = sample_last;
                    rem_next   = sample_last ? (act - TAPS_W'(1)) : '0;
                end
            end
            ST_CALC:
            begin
                if (capture)
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - TAPS_W'(1);
                        cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        last_next  = 1'b0;
                    end
                end
                else if (!done_calc)
                begin
                    cnt_next = cnt_reg + TAPS_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (capture)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            taps_reg    <= TAPS_RESET;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                taps_reg <= cfg_data;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            m_value_reg <= acc_sel;
            m_last_reg  <= last_reg && (rem_reg == '0);
        end
    end

    assign act_taps = act;
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- sv/full_linear_convolution.sv -----
// Full linear convolution: a chain of TAPS tap cells under one sequencer.
// Each output forms the products, passes the partial sum down the active cells of
// the chain and is then registered into the output register. A sample closes the
// input until its computation ends; a last sample adds taps - 1 tail outputs.
// A coefficient write leaves the input side open.
// Reset (rst_n, asynchronous, active low) clears delay line and coefficients.
module full_linear_convolution #(
    parameter int TAPS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata = coef_index [4:0], data_value [20:5], zeros [23:21].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // tuser = req_type; tlast = sample_last.
    input  logic        s_tuser,
    input  logic        s_tlast,
    // Output stream: tdata = out_value [36:0], zeros [39:37]; tlast = out_last.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // Configuration: taps_in_use.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import flc_pkg::*;

    localparam int SEL_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] data_value;
    cell_ctrl_t               ctrl;
    logic [TAPS_W-1:0]        act_taps;
    logic signed [ACC_W-1:0]  acc_sel;
    logic signed [ACC_W-1:0]  out_value;
    logic [SEL_W-1:0]         sel_idx;
    logic signed [DATA_W-1:0] sample_w [TAPS];
    logic signed [ACC_W-1:0]  acc_w [TAPS];

    assign coef_index = s_tdata[IDX_W-1:0];
    assign data_value = s_tdata[IDX_W+DATA_W-1:IDX_W];

    // Sequencer and output register.
    flc_ctrl #(
        .TAPS(TAPS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .sample_last (s_tlast),
        .data_value  (data_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .acc_sel     (acc_sel),
        .ctrl        (ctrl),
        .act_taps    (act_taps),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_value     (out_value),
        .m_last      (m_tlast)
    );

    // Row of tap cells; samples and partial sums move toward higher indexes.
    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        logic signed [DATA_W-1:0] s_in;
        logic signed [ACC_W-1:0]  a_in;

        if (j == 0)
        begin : g_head
            assign s_in = ctrl.shift_data;
            assign a_in = '0;
        end
        else
        begin : g_body
            assign s_in = sample_w[j-1];
            assign a_in = acc_w[j-1];
        end

        flc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .coef_sel   (32'(coef_index) == 32'(j)),
            .tap_en     (32'(act_taps) > 32'(j)),
            .sample_in  (s_in),
            .coef_in    (data_value),
            .sample_out (sample_w[j]),
            .acc_in     (a_in),
            .acc_out    (acc_w[j])
        );
    end

    // The finished sum is taken at the last active cell.
    assign sel_idx = SEL_W'(act_taps - TAPS_W'(1));
    assign acc_sel = acc_w[sel_idx];

    assign m_tdata = {3'b000, out_value};

endmodule

// ----- sv/flc_check.sv -----
// Port-level checks for the full linear convolution block, bound to its top
// level. Depends on the top level's port list only.
module flc_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result stays put until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A sample transfer starts a computation, so the input side closes.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input still ready after a sample transfer");

    // A coefficient write finishes at once and the input side stays open.
    a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("input closed after a coefficient transfer");

    // A new result only appears at the end of a computation.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

endmodule

bind full_linear_convolution flc_check u_flc_check (.*);

// ----- test/tb_full_linear_convolution.sv -----
// Self-checking testbench for full_linear_convolution: sends coefficient and sample
// transfers, predicts each output with a FIR model kept in the bench, and checks them.
// Depends on flc_pkg and on the full_linear_convolution top level.
module tb_full_linear_convolution;
    import flc_pkg::*;

    localparam int NUM_TAPS      = 32;
    localparam int TAP_CAP       = (NUM_TAPS < RESULT_LIMIT) ? NUM_TAPS : RESULT_LIMIT;
    localparam int RANDOM_ITEMS  = 90;
    localparam int QUIET_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;

    // One expected output transfer.
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } conv_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    // Bench copy of the filter state and the taps register.
    logic signed [DATA_W-1:0] model_delay [NUM_TAPS];
    logic signed [DATA_W-1:0] model_coef [NUM_TAPS];
    logic [TAPS_W-1:0]        model_taps;
    conv_out_t                pending_outputs [$];
    conv_out_t                check_want;

    logic idle_en = 1'b1;
    logic hold_request = 1'b0;
    int   items_sent = 0;
    int   outputs_checked = 0;
    int   frames_sent = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    full_linear_convolution #(
        .TAPS(NUM_TAPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d outputs still expected",
                     cycle_count, pending_outputs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Push a new sample into the newest end of the delay line.
    function automatic void shift_sample(logic signed [DATA_W-1:0] s);
        for (int j = NUM_TAPS - 1; j > 0; j--)
            model_delay[j] = model_delay[j - 1];
        model_delay[0] = s;
    endfunction

    // Full-precision dot product of the active taps.
    function automatic logic signed [ACC_W-1:0] fir_sum(int taps);
        logic signed [ACC_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < taps; j++)
            acc = acc + model_delay[j] * model_coef[j];
        return acc;
    endfunction

    // Update the model with one accepted transfer and queue the outputs it causes.
    function automatic void predict_item(logic req, logic [IDX_W-1:0] idx,
                                         logic signed [DATA_W-1:0] val, logic last);
        int taps;
        if (req == REQ_COEF)
        begin
            model_coef[idx] = val;
            return;
        end
        // Zero taps act as one; larger values are cut to the chain length.
        taps = (model_taps == 0) ? 1 : int'(model_taps);
        if (taps > TAP_CAP)
            taps = TAP_CAP;
        shift_sample(val);
        pending_outputs.push_back('{fir_sum(taps), last && taps == 1});
        // The last sample flushes the tail with zeros and then clears the line.
        if (last)
        begin
            for (int k = 1; k < taps; k++)
            begin
                shift_sample('0);
                pending_outputs.push_back('{fir_sum(taps), k == taps - 1});
            end
            for (int j = 0; j < NUM_TAPS; j++)
                model_delay[j] = '0;
        end
    endfunction

    // Random Q1.15 word, biased toward the extremes.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Send one input transfer, with an optional idle burst in front of it.
    task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val, input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, val, idx};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        predict_item(req, idx, val, last);
    endtask

    // Stop sending, wait for every expected output, then let the block settle.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the taps register over the configuration channel.
    task automatic write_taps(input logic [TAPS_W-1:0] taps);
        cfg_valid <= 1'b1;
        cfg_data  <= taps;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_taps = taps;
    endtask

    task automatic note_failure(input string what, input logic [ACC_W-1:0] want,
                                input logic [ACC_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("Mismatch on %s: expected %0d, got %0d", what,
                     $signed(want), $signed(got));
    endtask

    // Output monitor: each output transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            outputs_checked++;
            if (pending_outputs.size() == 0)
                note_failure("output with nothing pending", '0, m_tdata[ACC_W-1:0]);
            else
            begin
                check_want = pending_outputs.pop_front();
                if (m_tdata[ACC_W-1:0] !== check_want.value)
                    note_failure("out_value", check_want.value, m_tdata[ACC_W-1:0]);
                if (m_tlast !== check_want.last)
                    note_failure("out_last", ACC_W'(check_want.last), ACC_W'(m_tlast));
            end
        end
    end

    // Output ready: random idle bursts, plus one long hold when requested.
    initial
    begin : sink_ready
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // After reset the coefficients are zero and all 32 taps are in use.
    task automatic test_reset_state();
        send_item(REQ_SAMPLE, 5'd31, 16'sh7FFF, 1'b0);
        send_item(REQ_SAMPLE, 5'd0, 16'sh8000, 1'b1);
        frames_sent++;
    endtask

    // One tap: the sample's own output is the final one; zero taps behave the same.
    task automatic test_single_tap();
        finish_phase();
        write_taps(6'd1);
        send_item(REQ_COEF, 5'd0, 16'sh8000, 1'b0);
        send_item(REQ_SAMPLE, 5'd0, 16'sh8000, 1'b1);
        finish_phase();
        write_taps(6'd0);
        send_item(REQ_SAMPLE, 5'd0, 16'sh7FFF, 1'b0);
        send_item(REQ_SAMPLE, 5'd31, -16'sd1, 1'b1);
        frames_sent += 2;
    endtask

    // A taps value above the chain length is cut down to it; last on a coefficient is ignored.
    task automatic test_taps_clamp();
        finish_phase();
        write_taps(6'd63);
        send_item(REQ_COEF, 5'd31, 16'sh7FFF, 1'b1);
        send_item(REQ_SAMPLE, 5'd0, 16'sh7FFF, 1'b1);
        frames_sent++;
    endtask

    // Largest positive and negative products summed over four taps.
    task automatic test_extreme_products();
        finish_phase();
        write_taps(6'd4);
        for (int i = 0; i < 4; i++)
            send_item(REQ_COEF, IDX_W'(i), 16'sh8000, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(REQ_SAMPLE, 5'd0, 16'sh8000, i == 3);
        send_item(REQ_COEF, 5'd1, 16'sh7FFF, 1'b0);
        send_item(REQ_SAMPLE, 5'd31, 16'sh8000, 1'b1);
        frames_sent += 2;
    endtask

    // Fewer taps mid-stream: older samples stay in the line but stop counting.
    task automatic test_midstream_change();
        finish_phase();
        write_taps(6'd4);
        send_item(REQ_SAMPLE, 5'd7, 16'sh1234, 1'b0);
        send_item(REQ_SAMPLE, 5'd8, -16'sd300, 1'b0);
        send_item(REQ_SAMPLE, 5'd9, 16'sh7FFF, 1'b0);
        finish_phase();
        write_taps(6'd2);
        send_item(REQ_SAMPLE, 5'd10, 16'sh8000, 1'b1);
        frames_sent++;
    endtask

    // Output held off for a long stretch while samples keep coming, so input stalls.
    task automatic test_output_backpressure();
        finish_phase();
        write_taps(6'd3);
        hold_request = 1'b1;
        for (int i = 0; i < 14; i++)
            send_item(REQ_SAMPLE, IDX_W'(i), pick_value(), i == 13);
        frames_sent++;
    endtask

    // Random frames: taps setting, a few coefficient writes, then a sample stream.
    task automatic test_random_frames();
        int                stop_at;
        int                span;
        int                n_coef;
        int                n_samp;
        int                pick;
        logic [TAPS_W-1:0] taps_val;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            // Idling stops for the last stretch of the run.
            idle_en = (stop_at - items_sent) > QUIET_ITEMS;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                taps_val = TAPS_W'($urandom_range(1, 6));
            else if (pick == 7)
                taps_val = '0;
            else if (pick == 8)
                taps_val = TAPS_W'(NUM_TAPS);
            else
                taps_val = TAPS_W'($urandom_range(33, 63));
            span = (taps_val == 0) ? 1 : ((taps_val > TAP_CAP) ? TAP_CAP : int'(taps_val));
            finish_phase();
            write_taps(taps_val);
            n_coef = $urandom_range(0, (span < 6) ? span : 6);
            for (int i = 0; i < n_coef; i++)
                send_item(REQ_COEF,
                          IDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                                             : $urandom_range(0, 31)),
                          pick_value(), 1'($urandom_range(0, 1)));
            // Mostly closed frames; a few stay open and carry their samples forward.
            n_samp = $urandom_range(1, 8);
            for (int i = 0; i < n_samp; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(REQ_COEF, IDX_W'($urandom_range(0, span - 1)), pick_value(),
                              1'($urandom_range(0, 1)));
                send_item(REQ_SAMPLE, IDX_W'($urandom_range(0, 31)), pick_value(),
                          (i == n_samp - 1) && ($urandom_range(0, 7) != 0));
            end
            frames_sent++;
        end
    endtask

    // Test sequence.
    initial
    begin
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            model_delay[j] = '0;
            model_coef[j]  = '0;
        end
        model_taps = TAPS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_tap();
        test_taps_clamp();
        test_extreme_products();
        test_midstream_change();
        test_output_backpressure();
        test_random_frames();
        finish_phase();

        $display("Covered %0d input transfers in %0d frames and %0d output transfers,",
                 items_sent, frames_sent, outputs_checked);
        $display("with taps settings from 0 to 63, a long output hold and %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/flc_pkg.sv
sv/flc_cell.sv
sv/flc_ctrl.sv
sv/full_linear_convolution.sv
sv/flc_check.sv
test/tb_full_linear_convolution.sv
